### rtl/sab_pkg.sv
// Package with the shared constants and controller/datapath interface types.
package sab_pkg;

  localparam int MAX_LEN = 64;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int SYM_W   = 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // store an accepted symbol
    logic init;      // seed the order table and the insertion counter
    logic start_ins; // take the next position as the key to insert
    logic cap_c;     // capture the compared entry and clear the offset
    logic t_inc;     // step to the next symbol of both suffixes
    logic shift;     // move the compared entry up one slot
    logic place;     // write the key into its slot
    logic rd_sel_e;  // address the order table by the emit counter
    logic e_clear;   // clear the emit counter
    logic out_load;  // load the result registers
    logic e_inc;     // step the emit counter
    logic finish;    // clear the text length and overflow flag
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic i_done;
    logic j_one;
    logic less;
    logic greater;
    logic e_last;
  } sts_t;

endpackage

### rtl/sab_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/sab_datapath.sv
// Datapath: text and order memories, counters, suffix compare and result registers.
module sab_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  sab_pkg::cmd_t              cmd,
  output sab_pkg::sts_t              sts,
  input  logic [sab_pkg::SYM_W-1:0]  symbol,
  output logic [sab_pkg::ADDR_W-1:0] suffix_start,
  output logic                       last_result,
  output logic                       truncated
);

  logic [sab_pkg::LEN_W-1:0]  len;
  logic                       ovf;
  logic [sab_pkg::LEN_W-1:0]  i;
  logic [sab_pkg::ADDR_W-1:0] j;
  logic [sab_pkg::ADDR_W-1:0] key;
  logic [sab_pkg::ADDR_W-1:0] c;
  logic [sab_pkg::LEN_W-1:0]  t;
  logic [sab_pkg::ADDR_W-1:0] e;
  logic                       ma;
  logic                       mb;

  logic                       full;
  logic [sab_pkg::LEN_W:0]    sa;
  logic [sab_pkg::LEN_W:0]    sb;
  logic [sab_pkg::SYM_W-1:0]  ba;
  logic [sab_pkg::SYM_W-1:0]  bb;
  logic                       ord_we;
  logic [sab_pkg::ADDR_W-1:0] ord_waddr;
  logic [sab_pkg::ADDR_W-1:0] ord_wdata;
  logic [sab_pkg::ADDR_W-1:0] ord_raddr;
  logic [sab_pkg::ADDR_W-1:0] ord_rdata;

  assign full = (len == sab_pkg::LEN_W'(sab_pkg::MAX_LEN));
  assign sa   = (sab_pkg::LEN_W+1)'(key) + (sab_pkg::LEN_W+1)'(t);
  assign sb   = (sab_pkg::LEN_W+1)'(c) + (sab_pkg::LEN_W+1)'(t);

  sab_ram #(.WIDTH(sab_pkg::SYM_W), .DEPTH(sab_pkg::MAX_LEN)) u_text_a (
    .clk(clk), .we(cmd.load && !full), .waddr(len[sab_pkg::ADDR_W-1:0]), .wdata(symbol),
    .raddr(sa[sab_pkg::ADDR_W-1:0]), .rdata(ba)
  );

  sab_ram #(.WIDTH(sab_pkg::SYM_W), .DEPTH(sab_pkg::MAX_LEN)) u_text_b (
    .clk(clk), .we(cmd.load && !full), .waddr(len[sab_pkg::ADDR_W-1:0]), .wdata(symbol),
    .raddr(sb[sab_pkg::ADDR_W-1:0]), .rdata(bb)
  );

  assign ord_we    = cmd.init || cmd.shift || cmd.place;
  assign ord_waddr = cmd.init ? '0 : j;
  assign ord_wdata = cmd.init ? '0 : (cmd.shift ? c : key);
  assign ord_raddr = cmd.rd_sel_e ? e : j - 1'b1;

  sab_ram #(.WIDTH(sab_pkg::ADDR_W), .DEPTH(sab_pkg::MAX_LEN)) u_order (
    .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
    .raddr(ord_raddr), .rdata(ord_rdata)
  );

  // A position at or past the text length is a missing symbol, lowest of all.
  assign sts.less    = (ma && !mb) || (!ma && !mb && (ba < bb));
  assign sts.greater = (!ma && mb) || (!ma && !mb && (ba > bb));
  assign sts.i_done  = (i == len);
  assign sts.j_one   = (j == sab_pkg::ADDR_W'(1));
  assign sts.e_last  = ((sab_pkg::LEN_W'(e) + 1'b1) == len);

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
      ovf <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (full) begin
          ovf <= 1'b1;
        end else begin
          len <= len + 1'b1;
        end
      end
      if (cmd.finish) begin
        len <= '0;
        ovf <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ma <= (sa >= (sab_pkg::LEN_W+1)'(len));
    mb <= (sb >= (sab_pkg::LEN_W+1)'(len));
    if (cmd.init) begin
      i <= sab_pkg::LEN_W'(1);
    end
    if (cmd.place) begin
      i <= i + 1'b1;
    end
    if (cmd.start_ins) begin
      key <= i[sab_pkg::ADDR_W-1:0];
      j   <= i[sab_pkg::ADDR_W-1:0];
    end
    if (cmd.shift) begin
      j <= j - 1'b1;
    end
    if (cmd.cap_c) begin
      c <= ord_rdata;
      t <= '0;
    end
    if (cmd.t_inc) begin
      t <= t + 1'b1;
    end
    if (cmd.e_clear) begin
      e <= '0;
    end
    if (cmd.e_inc) begin
      e <= e + 1'b1;
    end
    if (cmd.out_load) begin
      suffix_start <= ord_rdata;
      last_result  <= sts.e_last;
      truncated    <= ovf;
    end
  end

endmodule

### rtl/sab_controller.sv
// Controller: state machine sequencing load, insertion sort and emit.
module sab_controller (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          final_symbol,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  sab_pkg::sts_t sts,
  output sab_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_NEXT, ST_FETCH, ST_CAP, ST_CMPRD, ST_CMP,
    ST_SHIFT, ST_PLACE, ST_ERD, ST_EWAIT, ST_EOUT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        cmd.load = in_valid;
        if (in_valid && final_symbol) state_next = ST_INIT;
      end
      ST_INIT: begin
        cmd.init   = 1'b1;
        state_next = ST_NEXT;
      end
      ST_NEXT: begin
        if (sts.i_done) begin
          cmd.e_clear = 1'b1;
          state_next  = ST_ERD;
        end else begin
          cmd.start_ins = 1'b1;
          state_next    = ST_FETCH;
        end
      end
      ST_FETCH: state_next = ST_CAP;
      ST_CAP: begin
        cmd.cap_c  = 1'b1;
        state_next = ST_CMPRD;
      end
      ST_CMPRD: state_next = ST_CMP;
      ST_CMP: begin
        if (sts.less) begin
          state_next = ST_SHIFT;
        end else if (sts.greater) begin
          state_next = ST_PLACE;
        end else begin
          cmd.t_inc  = 1'b1;
          state_next = ST_CMPRD;
        end
      end
      ST_SHIFT: begin
        cmd.shift  = 1'b1;
        state_next = sts.j_one ? ST_PLACE : ST_FETCH;
      end
      ST_PLACE: begin
        cmd.place  = 1'b1;
        state_next = ST_NEXT;
      end
      ST_ERD: begin
        cmd.rd_sel_e = 1'b1;
        state_next   = ST_EWAIT;
      end
      ST_EWAIT: begin
        cmd.rd_sel_e = 1'b1;
        cmd.out_load = 1'b1;
        state_next   = ST_EOUT;
      end
      ST_EOUT: begin
        cmd.rd_sel_e = 1'b1;
        if (!out_stall) begin
          if (sts.e_last) begin
            cmd.finish = 1'b1;
            state_next = ST_IDLE;
          end else begin
            cmd.e_inc  = 1'b1;
            state_next = ST_ERD;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_EWAIT) begin
        out_valid <= 1'b1;
      end else if (state == ST_EOUT && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/suffix_array_builder.sv
// Top level of the suffix array builder: controller plus datapath.
//
//   channel | signals                                  | direction
//   input   | in_valid, in_stall, symbol, final_symbol | symbols in
//   output  | out_valid, out_stall, suffix_start,      | sorted suffix
//           | last_result, truncated                   | starts out
//
// The final symbol starts the build, an insertion sort that compares suffixes
// byte by byte through two reads of the text memory per cycle. Each comparison
// steps through fetch, capture, compare read and compare, then shift or place;
// each equal leading byte repeats the compare read and compare. While emitting,
// each result passes through the read, wait and output states.
// Reset (rst, synchronous) clears the text length, the overflow flag and the
// state machine; memory contents are not cleared.
// A stalled result holds until it is taken; no symbol is taken meanwhile.
module suffix_array_builder (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [sab_pkg::SYM_W-1:0]  symbol,
  input  logic                       final_symbol,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [sab_pkg::ADDR_W-1:0] suffix_start,
  output logic                       last_result,
  output logic                       truncated
);

  // Command and status groups between the controller and the datapath.
  sab_pkg::cmd_t cmd;
  sab_pkg::sts_t sts;

  sab_controller u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .final_symbol(final_symbol),
    .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
    .sts(sts), .cmd(cmd)
  );

  sab_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .symbol(symbol),
    .suffix_start(suffix_start), .last_result(last_result), .truncated(truncated)
  );

endmodule

### rtl/sab_checker.sv
// Port-level checker for the suffix array builder, bound to the top level.
module sab_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       final_symbol,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [sab_pkg::ADDR_W-1:0] suffix_start,
  input logic                       last_result
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(suffix_start))
    else $error("stalled result changed");

  a_busy_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("symbol taken while emitting");

  a_final_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && final_symbol |=> in_stall)
    else $error("no build after final symbol");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_result |=> !out_valid)
    else $error("result after last entry");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind suffix_array_builder sab_checker u_sab_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .final_symbol(final_symbol), .out_valid(out_valid), .out_stall(out_stall),
  .suffix_start(suffix_start), .last_result(last_result)
);
